// ----- rtl/mlcfp_pkg.sv -----
// Shared types, constants and the CRC-32 byte step for the frame parser.
// No dependencies; imported by every module of the block.
package mlcfp_pkg;

    localparam int HEADER_BYTES  = 4;
    localparam int LENGTH_OFFSET = 1;
    localparam int MIN_FRAME     = HEADER_BYTES + 4;

    localparam logic [7:0]  LENGTH_OFFSET_B = 8'(LENGTH_OFFSET);
    localparam logic [8:0]  MIN_FRAME_W     = 9'(MIN_FRAME);
    localparam logic [7:0]  MIN_FRAME_B     = 8'(MIN_FRAME);
    localparam logic [7:0]  CRC_LAG         = 8'd4;

    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_CRC_FAIL = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [1:0] ST_BUSY     = 2'd3;

    localparam logic [1:0] CFG_MAGIC_BYTE      = 2'd0;
    localparam logic [1:0] CFG_MAX_FRAME_BYTES = 2'd1;

    typedef struct packed {
        logic       emit;
        logic [7:0] out_byte;
        logic [7:0] byte_offset;
        logic       frame_end;
        logic [1:0] frame_status;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ----- rtl/mlcfp_parser.sv -----
// Frame state (offset, length, running CRC, trailer shift) and the per-byte
// decision logic. Depends on mlcfp_pkg.
module mlcfp_parser
    import mlcfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic [7:0] magic_byte,
    input  logic [7:0] max_frame_bytes,
    output result_t    result
);

    logic [7:0]  frame_offset_reg, frame_offset_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [31:0] running_crc_reg,  running_crc_next;
    logic [31:0] trailer_crc_reg,  trailer_crc_next;

    logic        hunting;
    logic        drop;
    logic [7:0]  base_len;
    logic [31:0] base_crc;
    logic [31:0] base_tr;
    logic [7:0]  len_n;
    logic [31:0] crc_n;
    logic [31:0] tr_n;
    logic [8:0]  off_p1;
    logic        bad_len;
    logic        done;
    logic        frame_end;
    logic [1:0]  status;

    always_comb begin
        hunting  = (frame_offset_reg == 8'd0);
        drop     = hunting && (in_byte != magic_byte);
        base_len = hunting ? 8'd0 : frame_length_reg;
        base_crc = hunting ? CRC_INIT : running_crc_reg;
        base_tr  = hunting ? 32'd0 : trailer_crc_reg;

        len_n = (frame_offset_reg == LENGTH_OFFSET_B) ? in_byte : base_len;
        crc_n = (frame_offset_reg >= CRC_LAG) ? crc_byte(base_crc, base_tr[7:0])
                                               : base_crc;
        tr_n  = {in_byte, base_tr[31:8]};

        off_p1  = {1'b0, frame_offset_reg} + 9'd1;
        bad_len = (off_p1 == MIN_FRAME_W) &&
                  ((len_n < MIN_FRAME_B) || (len_n > max_frame_bytes));
        done    = !bad_len && (off_p1 >= MIN_FRAME_W) && (off_p1 == {1'b0, len_n});

        frame_end = bad_len || done;
        priority if (bad_len) begin
            status = ST_BAD_LEN;
        end else if (done) begin
            status = (crc_n == tr_n) ? ST_VALID : ST_CRC_FAIL;
        end else begin
            status = ST_BUSY;
        end

        result.emit         = step && !drop;
        result.out_byte     = in_byte;
        result.byte_offset  = frame_offset_reg;
        result.frame_end    = frame_end;
        result.frame_status = status;

        frame_offset_next = frame_offset_reg;
        frame_length_next = frame_length_reg;
        running_crc_next  = running_crc_reg;
        trailer_crc_next  = trailer_crc_reg;
        if (step && !drop) begin
            if (frame_end) begin
                frame_offset_next = 8'd0;
                frame_length_next = 8'd0;
                running_crc_next  = CRC_INIT;
                trailer_crc_next  = 32'd0;
            end else begin
                frame_offset_next = off_p1[7:0];
                frame_length_next = len_n;
                running_crc_next  = crc_n;
                trailer_crc_next  = tr_n;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_offset_reg <= 8'd0;
            frame_length_reg <= 8'd0;
            running_crc_reg  <= CRC_INIT;
            trailer_crc_reg  <= 32'd0;
        end else begin
            frame_offset_reg <= frame_offset_next;
            frame_length_reg <= frame_length_next;
            running_crc_reg  <= running_crc_next;
            trailer_crc_reg  <= trailer_crc_next;
        end
    end

endmodule

// ----- rtl/magic_length_crc32_frame_parser_unit.sv -----
// Top level of the magic/length/CRC-32 frame parser: input register, config
// registers, output register. Depends on mlcfp_pkg and mlcfp_parser.
//
// One byte enters per cycle while m_tready does not stall the output register
// and, unless dropped while hunting for the magic byte, passes through the input
// register and then the output register to leave as one output transaction.
// Throughput is one byte per cycle unless m_tready stalls the output. Each output
// transaction carries the byte and its frame offset; tlast marks the byte that
// completes or aborts a frame, and tuser gives the status (valid, checksum
// fail, invalid length, in progress). Config writes are taken at any time and
// must only be issued while the block is idle.
module magic_length_crc32_frame_parser_unit
    import mlcfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] byte_offset
    output logic        m_tlast,   // frame_end
    output logic [1:0]  m_tuser,   // [1:0] frame_status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [7:0]  magic_byte_reg;
    logic [7:0]  max_frame_bytes_reg;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg;
    logic        out_last_reg;
    logic [1:0]  out_user_reg;
    logic        advance;
    logic        step;
    result_t     result;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign step      = in_valid_reg && advance;
    assign cfg_ready = 1'b1;

    mlcfp_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (step),
        .in_byte         (in_byte_reg),
        .magic_byte      (magic_byte_reg),
        .max_frame_bytes (max_frame_bytes_reg),
        .result          (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_byte_reg      <= 8'd0;
            max_frame_bytes_reg <= 8'd255;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MAGIC_BYTE:      magic_byte_reg      <= cfg_data;
                CFG_MAX_FRAME_BYTES: max_frame_bytes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_comb begin
        if (advance) begin
            out_valid_next = result.emit;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.emit) begin
            out_data_reg <= {result.byte_offset, result.out_byte};
            out_last_reg <= result.frame_end;
            out_user_reg <= result.frame_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_end_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser != ST_BUSY)))
        else $error("frame end and status disagree");

    a_bad_len_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_BAD_LEN) |-> (m_tdata[15:8] == MIN_FRAME_B - 8'd1))
        else $error("invalid length reported at wrong offset");

    a_check_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_VALID || m_tuser == ST_CRC_FAIL))
            |-> (m_tdata[15:8] >= MIN_FRAME_B - 8'd1))
        else $error("checksum result before minimum frame length");
`endif

endmodule
